// ----- hw/rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the delimiter stream splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int DELIM_MAX   = 8;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int DELIM_W     = DELIM_MAX * BYTE_W;
	localparam int CNT_W       = $clog2(DELIM_MAX + 1);
	localparam int IDX_W       = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 4;

	localparam logic REG_LEN   = 1'b0;
	localparam logic REG_DELIM = 1'b1;

	localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);
	localparam logic [DELIM_W-1:0] DELIM_RESET = DELIM_W'(44);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              segment_end;
		logic              text_end;
	} res_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

endpackage

// ----- hw/rtl/delimiter_stream_splitter.sv -----
// ----------------------------------------------------------------------------
// delimiter_stream_splitter
// Splits a byte stream into segments at each occurrence of a delimiter.
// ----------------------------------------------------------------------------
// Input words (item_valid/item_stall) carry data_byte, byte_present and
// text_last; a word with neither flag is taken and gives nothing. Result
// words (res_valid/res_stall) carry either a segment data byte (out_valid)
// or a segment end; text_end marks the last result of a text.
// Bytes wait in a window of up to delim_len-1 entries; a byte that completes
// the delimiter turns the window into one segment end.
// Throughput: one input word per cycle while no result stalls and each word
// gives at most one result. A text_last word flushes the window byte by byte,
// then gives the final segment end with text_end; a byte that leaves the
// window short of delim_len gives no result. Each word passes the input stage,
// the 4-entry command queue and the matcher with its result register.
// Reset clears the window, the queue and the result valid flag and loads
// delim_len = 1, delim_bytes = comma. Registers are to be written over the
// APB port only while no text is in flight; the block does not enforce this.
// A stalled result holds; the queue then fills and item_stall rises.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dss_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dss_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dss_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [dss_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            byte_present,
	input  logic                            text_last,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [dss_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_valid,
	output logic                            segment_end,
	output logic                            text_end
);

	logic [dss_pkg::LEN_W-1:0]   len_q;
	logic [dss_pkg::DELIM_W-1:0] delim_q;
	logic                        wr_en;
	logic                        push, pop;
	dss_pkg::cmd_t               push_cmd, pop_cmd;
	dss_pkg::qstat_t             qstat;
	dss_pkg::res_t               res;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= dss_pkg::LEN_RESET;
			delim_q <= dss_pkg::DELIM_RESET;
		end else if (wr_en) begin
			unique case (paddr[3])
				dss_pkg::REG_LEN:   len_q   <= pwdata[dss_pkg::LEN_W-1:0];
				dss_pkg::REG_DELIM: delim_q <= pwdata[dss_pkg::DELIM_W-1:0];
				default:            len_q   <= len_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			dss_pkg::REG_LEN:   prdata = dss_pkg::CFG_DATA_W'(len_q);
			dss_pkg::REG_DELIM: prdata = dss_pkg::CFG_DATA_W'(delim_q);
			default:            prdata = '0;
		endcase
	end

	dss_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.text_last    (text_last),
		.qstat        (qstat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	dss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	dss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.delim_len   (len_q),
		.delim_bytes (delim_q),
		.qstat       (qstat),
		.pop_cmd     (pop_cmd),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	assign out_byte    = res.out_byte;
	assign out_valid   = res.out_valid;
	assign segment_end = res.segment_end;
	assign text_end    = res.text_end;

endmodule

// ----- hw/rtl/dss_front.sv -----
// ----------------------------------------------------------------------------
// dss_front
// Input stage: takes words, drops idle ones, registers the command for the queue.
// ----------------------------------------------------------------------------
module dss_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [dss_pkg::BYTE_W-1:0] data_byte,
	input  logic                       byte_present,
	input  logic                       text_last,
	input  dss_pkg::qstat_t            qstat,
	output logic                       push,
	output dss_pkg::cmd_t              push_cmd
);

	logic          v_s1;
	dss_pkg::cmd_t cmd_s1;
	logic          load;

	assign item_stall = v_s1 & qstat.full;
	assign push       = v_s1 & ~qstat.full;
	assign push_cmd   = cmd_s1;
	assign load       = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!item_stall) begin
			v_s1 <= item_valid & (byte_present | text_last);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1.data_byte <= data_byte;
			cmd_s1.has_byte  <= byte_present;
			cmd_s1.last      <= text_last;
		end
	end

endmodule

// ----- hw/rtl/dss_fifo.sv -----
// ----------------------------------------------------------------------------
// dss_fifo
// Short command queue between the input stage and the matcher.
// ----------------------------------------------------------------------------
module dss_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dss_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output dss_pkg::cmd_t   pop_cmd,
	output dss_pkg::qstat_t qstat
);

	dss_pkg::cmd_t                   mem_q [dss_pkg::QDEPTH];
	logic [dss_pkg::QPTR_W-1:0]      wr_q;
	logic [dss_pkg::QPTR_W-1:0]      rd_q;
	logic [dss_pkg::QCNT_W-1:0]      cnt_q;

	assign qstat.full     = (cnt_q == dss_pkg::QCNT_W'(dss_pkg::QDEPTH));
	assign qstat.nonempty = (cnt_q != '0);
	assign pop_cmd        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

// ----- hw/rtl/dss_back.sv -----
// ----------------------------------------------------------------------------
// dss_back
// Pending window, delim compare, result reg; one result per unstalled cycle.
// ----------------------------------------------------------------------------
module dss_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dss_pkg::LEN_W-1:0]   delim_len,
	input  logic [dss_pkg::DELIM_W-1:0] delim_bytes,
	input  dss_pkg::qstat_t             qstat,
	input  dss_pkg::cmd_t               pop_cmd,
	output logic                        pop,
	output logic                        res_valid,
	input  logic                        res_stall,
	output dss_pkg::res_t               res
);

	logic [dss_pkg::BYTE_W-1:0] win_q [dss_pkg::DELIM_MAX];
	logic [dss_pkg::BYTE_W-1:0] win_n [dss_pkg::DELIM_MAX];
	logic [dss_pkg::BYTE_W-1:0] win_sh [dss_pkg::DELIM_MAX];
	logic [dss_pkg::CNT_W-1:0]  cnt_q, cnt_n;
	logic                       bw_q, bw_n, lw_q, lw_n;
	logic                       res_v_q;
	dss_pkg::res_t              res_q;
	logic [dss_pkg::CNT_W-1:0]  len;
	logic                       room, step, emit, match;
	dss_pkg::res_t              emit_res;

	always_comb begin
		if (delim_len == '0)
			len = dss_pkg::CNT_W'(1);
		else if (delim_len > dss_pkg::LEN_W'(dss_pkg::DELIM_MAX))
			len = dss_pkg::CNT_W'(dss_pkg::DELIM_MAX);
		else
			len = dss_pkg::CNT_W'(delim_len);
	end

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < dss_pkg::DELIM_MAX; i++) begin
			if ((dss_pkg::CNT_W'(i) < len) &&
			    (win_q[i] != delim_bytes[i*dss_pkg::BYTE_W +: dss_pkg::BYTE_W]))
				match = 1'b0;
		end
		for (int i = 0; i < dss_pkg::DELIM_MAX - 1; i++) win_sh[i] = win_q[i+1];
		win_sh[dss_pkg::DELIM_MAX-1] = '0;
	end

	assign room = ~res_v_q | ~res_stall;
	assign step = (bw_q | lw_q) & room;

	always_comb begin
		win_n    = win_q;
		cnt_n    = cnt_q;
		bw_n     = bw_q;
		lw_n     = lw_q;
		emit     = 1'b0;
		emit_res = '0;
		if (step) begin
			if (bw_q) begin
				if (cnt_q > len) begin
					emit               = 1'b1;
					emit_res.out_byte  = win_q[0];
					emit_res.out_valid = 1'b1;
					win_n              = win_sh;
					cnt_n              = cnt_q - 1'b1;
				end else if (cnt_q == len) begin
					bw_n = 1'b0;
					emit = 1'b1;
					if (match) begin
						emit_res.segment_end = 1'b1;
						for (int i = 0; i < dss_pkg::DELIM_MAX; i++) win_n[i] = '0;
						cnt_n = '0;
					end else begin
						emit_res.out_byte  = win_q[0];
						emit_res.out_valid = 1'b1;
						win_n              = win_sh;
						cnt_n              = cnt_q - 1'b1;
					end
				end else begin
					bw_n = 1'b0;
				end
			end else begin
				emit = 1'b1;
				if (cnt_q != '0) begin
					emit_res.out_byte  = win_q[0];
					emit_res.out_valid = 1'b1;
					win_n              = win_sh;
					cnt_n              = cnt_q - 1'b1;
				end else begin
					emit_res.segment_end = 1'b1;
					emit_res.text_end    = 1'b1;
					lw_n                 = 1'b0;
					for (int i = 0; i < dss_pkg::DELIM_MAX; i++) win_n[i] = '0;
					cnt_n = '0;
				end
			end
		end
		pop = qstat.nonempty & ~bw_n & ~lw_n;
		if (pop) begin
			bw_n = pop_cmd.has_byte;
			lw_n = pop_cmd.last;
			if (pop_cmd.has_byte && (cnt_n < dss_pkg::CNT_W'(dss_pkg::DELIM_MAX))) begin
				win_n[cnt_n[dss_pkg::IDX_W-1:0]] = pop_cmd.data_byte;
				cnt_n = cnt_n + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bw_q    <= 1'b0;
			lw_q    <= 1'b0;
			res_v_q <= 1'b0;
			for (int i = 0; i < dss_pkg::DELIM_MAX; i++) win_q[i] <= '0;
		end else begin
			cnt_q <= cnt_n;
			bw_q  <= bw_n;
			lw_q  <= lw_n;
			win_q <= win_n;
			if (room) res_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (room && emit) res_q <= emit_res;
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule
